// ===== hdl/bbem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbem_pkg
// Shared constants, register map and controller/datapath interface types of
// the box blur block.
// ----------------------------------------------------------------------------
package bbem_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_RADIUS = 15;

	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register field widths
	localparam int FW_WIDTH    = 7;
	localparam int FW_HEIGHT   = 7;
	localparam int FW_RADIUS   = 4;
	localparam int FW_CHANNELS = 2;

	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_BLUR_RADIUS   = 3'd2;
	localparam logic [2:0] REG_EDGE_MODE     = 3'd3;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;

	localparam logic       OP_PUSH        = 1'b0;
	localparam logic       EDGE_REPLICATE = 1'b0;
	localparam logic [1:0] CH_COLOUR      = 2'd3;

	typedef struct packed {
		logic accept;
		logic win_init;
		logic fold_load;
		logic fold_axis_y;
		logic fold_step;
		logic store_sy;
		logic store_sx;
		logic rd_en;
		logic acc;
		logic div_load;
		logic div_step;
		logic out_load;
	} bbem_cmd_t;

	typedef struct packed {
		logic ready;
		logic fold_done;
		logic row_done;
		logic win_done;
		logic div_done;
		logic out_free;
	} bbem_sts_t;

endpackage

// ===== hdl/bbem_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbem_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bbem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/bbem_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbem_regs
// Configuration register file on the APB-style port; saturates sizes into
// range and flags a frame restart on every write to a defined register.
// ----------------------------------------------------------------------------
module bbem_regs
	import bbem_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	localparam int XW = $clog2(MAX_WIDTH + 1),
	localparam int YW = $clog2(MAX_HEIGHT + 1),
	localparam int RW = $clog2(MAX_RADIUS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [XW-1:0]     width,
	output logic [YW-1:0]     height,
	output logic [RW-1:0]     radius,
	output logic              mirror,
	output logic [1:0]        channels,
	output logic              restart
);

	logic [XW-1:0] width_q;
	logic [YW-1:0] height_q;
	logic [RW-1:0] radius_q;
	logic          mirror_q;
	logic [1:0]    channels_q;
	logic          wr;
	logic [2:0]    idx;

	function automatic int clamp_i(input int v, input int hi);
		int r;
		r = v;
		if (r < 1) r = 1;
		if (r > hi) r = hi;
		return r;
	endfunction

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	always_comb begin
		restart = 1'b0;
		prdata  = '0;
		case (idx)
			REG_FRAME_WIDTH: begin
				restart = wr;
				prdata  = DATA_W'(width_q);
			end
			REG_FRAME_HEIGHT: begin
				restart = wr;
				prdata  = DATA_W'(height_q);
			end
			REG_BLUR_RADIUS: begin
				restart = wr;
				prdata  = DATA_W'(radius_q);
			end
			REG_EDGE_MODE: begin
				restart = wr;
				prdata  = DATA_W'(mirror_q);
			end
			REG_CHANNEL_COUNT: begin
				restart = wr;
				prdata  = DATA_W'(channels_q);
			end
			default: begin
				restart = 1'b0;
				prdata  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= XW'(clamp_i(64, MAX_WIDTH));
			height_q   <= YW'(clamp_i(64, MAX_HEIGHT));
			radius_q   <= RW'(clamp_i(1, MAX_RADIUS));
			mirror_q   <= EDGE_REPLICATE;
			channels_q <= 2'd1;
		end else if (wr) begin
			case (idx)
				REG_FRAME_WIDTH:
					width_q <= XW'(clamp_i(int'(pwdata[FW_WIDTH-1:0]), MAX_WIDTH));
				REG_FRAME_HEIGHT:
					height_q <= YW'(clamp_i(int'(pwdata[FW_HEIGHT-1:0]), MAX_HEIGHT));
				REG_BLUR_RADIUS:
					radius_q <= RW'(clamp_i(int'(pwdata[FW_RADIUS-1:0]), MAX_RADIUS));
				REG_EDGE_MODE:     mirror_q   <= pwdata[0];
				REG_CHANNEL_COUNT: channels_q <= pwdata[FW_CHANNELS-1:0];
				default: ;
			endcase
		end
	end

	assign width    = width_q;
	assign height   = height_q;
	assign radius   = radius_q;
	assign mirror   = mirror_q;
	assign channels = channels_q;

endmodule

// ===== hdl/bbem_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbem_ctrl
// Sequencer: takes one request; if an output is ready, walks the window
// (fold row, fold column, read, accumulate), divides, hands the result over.
// ----------------------------------------------------------------------------
module bbem_ctrl
	import bbem_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  bbem_sts_t sts,
	output bbem_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_FY_LOAD, S_FY_RUN, S_FX_LOAD, S_FX_RUN,
		S_READ, S_ACC, S_DLOAD, S_DIV, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   stall_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid && !stall_q) begin
					cmd.accept = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.ready) begin
					cmd.win_init = 1'b1;
					state_d      = S_FY_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FY_LOAD: begin
				cmd.fold_load   = 1'b1;
				cmd.fold_axis_y = 1'b1;
				state_d         = S_FY_RUN;
			end
			S_FY_RUN: begin
				if (sts.fold_done) begin
					cmd.store_sy = 1'b1;
					state_d      = S_FX_LOAD;
				end else begin
					cmd.fold_step = 1'b1;
				end
			end
			S_FX_LOAD: begin
				cmd.fold_load = 1'b1;
				state_d       = S_FX_RUN;
			end
			S_FX_RUN: begin
				if (sts.fold_done) begin
					cmd.store_sx = 1'b1;
					state_d      = S_READ;
				end else begin
					cmd.fold_step = 1'b1;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (!sts.row_done) begin
					state_d = S_FX_LOAD;
				end else if (!sts.win_done) begin
					state_d = S_FY_LOAD;
				end else begin
					state_d = S_DLOAD;
				end
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_OUT: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

	assign item_stall = stall_q;

endmodule

// ===== hdl/bbem_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbem_dpath
// Datapath: frame positions, border fold unit, window sums, restoring
// divider for the rounded mean, and the output register.
// ----------------------------------------------------------------------------
module bbem_dpath
	import bbem_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	localparam int XW  = $clog2(MAX_WIDTH + 1),
	localparam int YW  = $clog2(MAX_HEIGHT + 1),
	localparam int RW  = $clog2(MAX_RADIUS + 1),
	localparam int MAW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bbem_cmd_t        cmd,
	output bbem_sts_t        sts,
	input  logic [XW-1:0]    width,
	input  logic [YW-1:0]    height,
	input  logic [RW-1:0]    radius,
	input  logic             mirror,
	input  logic [1:0]       channels,
	input  logic             restart,
	input  logic             operation,
	input  logic [CH_W-1:0]  sample_first,
	input  logic [CH_W-1:0]  sample_second,
	input  logic [CH_W-1:0]  sample_third,
	output logic             ram_wr_en,
	output logic [MAW-1:0]   ram_wr_addr,
	output logic [PIX_W-1:0] ram_wr_data,
	output logic             ram_rd_en,
	output logic [MAW-1:0]   ram_rd_addr,
	input  logic [PIX_W-1:0] ram_rd_data,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [CH_W-1:0]  blurred_first,
	output logic [CH_W-1:0]  blurred_second,
	output logic [CH_W-1:0]  blurred_third,
	output logic             frame_end
);

	localparam int LW       = (XW > YW) ? XW : YW;
	localparam int CW       = LW + RW + 2;
	localparam int FCW      = $clog2(RW + 1);
	localparam int AREA_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int ARW      = $clog2(AREA_MAX + 1);
	localparam int SW       = $clog2(AREA_MAX * 255 + AREA_MAX / 2 + 1);
	localparam int DCW      = $clog2(SW + 1);
	localparam int LIMW     = YW + RW + 1;

	logic colour;
	assign colour = (channels == CH_COLOUR);

	// ---------------- frame positions ----------------
	logic [XW-1:0] in_x_q, ox_q, sx_q;
	logic [YW-1:0] in_y_q, oy_q, sy_q;
	logic          last_out;
	logic [LIMW-1:0] lim;

	assign ram_wr_en   = cmd.accept && (operation == OP_PUSH) && (in_y_q < height);
	assign ram_wr_addr = MAW'(int'(in_y_q) * MAX_WIDTH + int'(in_x_q));
	assign ram_wr_data = colour ? {sample_third, sample_second, sample_first}
	                            : {{(2 * CH_W){1'b0}}, sample_first};
	assign last_out    = (ox_q == width - XW'(1)) && (oy_q == height - YW'(1));
	assign lim         = LIMW'(oy_q) + LIMW'(radius) + LIMW'(1);
	assign sts.ready   = (in_y_q >= height) || (LIMW'(in_y_q) >= lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_x_q <= '0;
			in_y_q <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
		end else if (restart || (cmd.out_load && last_out)) begin
			in_x_q <= '0;
			in_y_q <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
		end else begin
			if (ram_wr_en) begin
				if (in_x_q == width - XW'(1)) begin
					in_x_q <= '0;
					in_y_q <= in_y_q + YW'(1);
				end else begin
					in_x_q <= in_x_q + XW'(1);
				end
			end
			if (cmd.out_load) begin
				if (ox_q == width - XW'(1)) begin
					ox_q <= '0;
					oy_q <= oy_q + YW'(1);
				end else begin
					ox_q <= ox_q + XW'(1);
				end
			end
		end
	end

	// ---------------- window offsets ----------------
	logic signed [RW:0] dx_q, dy_q;
	logic        [RW:0] rad;

	assign rad          = {1'b0, radius};
	assign sts.row_done = (dx_q == rad);
	assign sts.win_done = (dy_q == rad);

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			dx_q <= -rad;
			dy_q <= -rad;
		end else if (cmd.acc) begin
			if (sts.row_done) begin
				dx_q <= -rad;
				dy_q <= dy_q + (RW + 1)'(1);
			end else begin
				dx_q <= dx_q + (RW + 1)'(1);
			end
		end
	end

	// ---------------- border fold unit ----------------
	logic [LW-1:0]        f_o, f_len, f_direct;
	logic [RW:0]          f_d;
	logic signed [CW-1:0] f_c, f_len_c, f_t, f_neg_c, f_neg_t;
	logic                 f_mod, f_inv;
	logic [RW-1:0]        f_m;
	logic [LW-1:0]        f_dir_q, f_len_q, f_rem_q, f_res;
	logic [RW-1:0]        f_m_q;
	logic                 f_mod_q, f_inv_q;
	logic [FCW-1:0]       f_cnt_q;
	logic [LW:0]          f_trial;

	assign f_o     = cmd.fold_axis_y ? LW'(oy_q) : LW'(ox_q);
	assign f_d     = cmd.fold_axis_y ? dy_q : dx_q;
	assign f_len   = cmd.fold_axis_y ? LW'(height) : LW'(width);
	assign f_c     = {{(CW - LW){1'b0}}, f_o} + {{(CW - RW - 1){f_d[RW]}}, f_d};
	assign f_len_c = {{(CW - LW){1'b0}}, f_len};
	assign f_t     = f_c - f_len_c - f_len_c + CW'(2);
	assign f_neg_c = -f_c;
	assign f_neg_t = -f_t;

	always_comb begin
		f_direct = '0;
		f_mod    = 1'b0;
		f_inv    = 1'b0;
		f_m      = '0;
		if (!f_c[CW-1] && (f_c < f_len_c)) begin
			f_direct = f_c[LW-1:0];
		end else if (mirror == EDGE_REPLICATE) begin
			f_direct = f_c[CW-1] ? '0 : f_len - LW'(1);
		end else if (f_c[CW-1]) begin
			f_mod = 1'b1;
			f_m   = f_neg_c[RW-1:0];
		end else if (f_t[CW-1] || (f_t == '0)) begin
			f_direct = f_neg_t[LW-1:0];
		end else begin
			// reflected index still negative: wrap it back from the top
			f_mod = 1'b1;
			f_inv = 1'b1;
			f_m   = f_t[RW-1:0];
		end
	end

	assign f_trial       = {f_rem_q, f_m_q[RW-1]};
	assign sts.fold_done = (f_cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.fold_load) begin
			f_dir_q <= f_direct;
			f_len_q <= f_len;
			f_rem_q <= '0;
			f_m_q   <= f_m;
			f_mod_q <= f_mod;
			f_inv_q <= f_inv;
			f_cnt_q <= f_mod ? FCW'(RW) : '0;
		end else if (cmd.fold_step) begin
			if (f_trial >= {1'b0, f_len_q}) begin
				f_rem_q <= LW'(f_trial - {1'b0, f_len_q});
			end else begin
				f_rem_q <= LW'(f_trial);
			end
			f_m_q   <= f_m_q << 1;
			f_cnt_q <= f_cnt_q - FCW'(1);
		end
	end

	always_comb begin
		if (!f_mod_q) begin
			f_res = f_dir_q;
		end else if (!f_inv_q) begin
			f_res = f_rem_q;
		end else if (f_rem_q == '0) begin
			f_res = '0;
		end else begin
			f_res = f_len_q - f_rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_sy) sy_q <= YW'(f_res);
		if (cmd.store_sx) sx_q <= XW'(f_res);
	end

	assign ram_rd_en   = cmd.rd_en;
	assign ram_rd_addr = MAW'(int'(sy_q) * MAX_WIDTH + int'(sx_q));

	// ---------------- sums and divider ----------------
	logic [2*(RW+1)-1:0] sq;
	logic [ARW-1:0]      area_q;
	logic [SW-1:0]       sum_q  [3];
	logic [SW-1:0]       dvd_q  [3];
	logic [ARW-1:0]      drem_q [3];
	logic [ARW:0]        dtrial [3];
	logic [DCW-1:0]      dcnt_q;

	assign sq = {{(RW + 1){1'b0}}, radius, 1'b1} * {{(RW + 1){1'b0}}, radius, 1'b1};
	assign sts.div_done = (dcnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			area_q <= ARW'(sq);
		end
		if (cmd.div_load) begin
			dcnt_q <= DCW'(SW);
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - DCW'(1);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_ch
		assign dtrial[k] = {drem_q[k], dvd_q[k][SW-1]};
		always_ff @(posedge clk) begin
			if (cmd.win_init) begin
				sum_q[k] <= '0;
			end else if (cmd.acc) begin
				sum_q[k] <= sum_q[k] + SW'(ram_rd_data[k*CH_W +: CH_W]);
			end
			if (cmd.div_load) begin
				dvd_q[k]  <= sum_q[k] + SW'(area_q >> 1);
				drem_q[k] <= '0;
			end else if (cmd.div_step) begin
				if (dtrial[k] >= {1'b0, area_q}) begin
					drem_q[k] <= ARW'(dtrial[k] - {1'b0, area_q});
					dvd_q[k]  <= {dvd_q[k][SW-2:0], 1'b1};
				end else begin
					drem_q[k] <= ARW'(dtrial[k]);
					dvd_q[k]  <= {dvd_q[k][SW-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- output register ----------------
	logic            res_valid_q;
	logic [CH_W-1:0] b0_q, b1_q, b2_q;
	logic            fe_q;

	assign sts.out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			b0_q <= dvd_q[0][CH_W-1:0];
			b1_q <= colour ? dvd_q[1][CH_W-1:0] : '0;
			b2_q <= colour ? dvd_q[2][CH_W-1:0] : '0;
			fe_q <= last_out;
		end
	end

	assign result_valid   = res_valid_q;
	assign blurred_first  = b0_q;
	assign blurred_second = b1_q;
	assign blurred_third  = b2_q;
	assign frame_end      = fe_q;

	// ---------------- checks ----------------
	a_read_after_fold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> sts.fold_done)
		else $error("frame store read while fold still running");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && last_out && !restart) |=> (in_y_q == '0 && oy_q == '0 && ox_q == '0))
		else $error("positions not cleared after frame end");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (dcnt_q != '0))
		else $error("divider stepped past its last bit");

endmodule

// ===== hdl/box_blur_edge_modes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_edge_modes
// Streaming box blur over a stored frame with replicate or mirror borders.
// ----------------------------------------------------------------------------
// One request is taken at a time. A push or flush that releases no output
// returns to idle after the ready check. One that releases an output walks
// the (2R+1)x(2R+1) window through the single read port of the frame store:
// a column fold, read and accumulate per window pixel and a row fold per
// window row (stepwise modulo for a mirrored coordinate below zero or still
// outside after reflection); then a restoring divide of one quotient bit per
// cycle (18 bits at the default size) and a load into the output register
// once it is free. The frame store has no reset pass.
// ----------------------------------------------------------------------------
module box_blur_edge_modes
	import bbem_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              operation,
	input  logic [CH_W-1:0]   sample_first,
	input  logic [CH_W-1:0]   sample_second,
	input  logic [CH_W-1:0]   sample_third,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [CH_W-1:0]   blurred_first,
	output logic [CH_W-1:0]   blurred_second,
	output logic [CH_W-1:0]   blurred_third,
	output logic              frame_end
);

	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int MAW   = $clog2(DEPTH);

	logic [XW-1:0]    width;
	logic [YW-1:0]    height;
	logic [RW-1:0]    radius;
	logic             mirror;
	logic [1:0]       channels;
	logic             restart;
	bbem_cmd_t        cmd;
	bbem_sts_t        sts;
	logic             ram_wr_en, ram_rd_en;
	logic [MAW-1:0]   ram_wr_addr, ram_rd_addr;
	logic [PIX_W-1:0] ram_wr_data, ram_rd_data;

	bbem_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_RADIUS(MAX_RADIUS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.width   (width),
		.height  (height),
		.radius  (radius),
		.mirror  (mirror),
		.channels(channels),
		.restart (restart)
	);

	bbem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bbem_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	bbem_dpath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_RADIUS(MAX_RADIUS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.width         (width),
		.height        (height),
		.radius        (radius),
		.mirror        (mirror),
		.channels      (channels),
		.restart       (restart),
		.operation     (operation),
		.sample_first  (sample_first),
		.sample_second (sample_second),
		.sample_third  (sample_third),
		.ram_wr_en     (ram_wr_en),
		.ram_wr_addr   (ram_wr_addr),
		.ram_wr_data   (ram_wr_data),
		.ram_rd_en     (ram_rd_en),
		.ram_rd_addr   (ram_rd_addr),
		.ram_rd_data   (ram_rd_data),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.blurred_first (blurred_first),
		.blurred_second(blurred_second),
		.blurred_third (blurred_third),
		.frame_end     (frame_end)
	);

endmodule

// ===== bench/blur_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_checker
// Watches the register port, the request channel and the result channel of the box blur,
// predicts every released output pixel from its own copy of the frame and
// the registers, and compares each output field with the oldest prediction.
// ----------------------------------------------------------------------------
module blur_checker
	import bbem_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              item_valid,
	input  logic              item_stall,
	input  logic              operation,
	input  logic [CH_W-1:0]   sample_first,
	input  logic [CH_W-1:0]   sample_second,
	input  logic [CH_W-1:0]   sample_third,
	input  logic              result_valid,
	input  logic              result_stall,
	input  logic [CH_W-1:0]   blurred_first,
	input  logic [CH_W-1:0]   blurred_second,
	input  logic [CH_W-1:0]   blurred_third,
	input  logic              frame_end,
	output int                mismatches,
	output int                outstanding
);

	localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	typedef struct {
		logic [CH_W-1:0] first;
		logic [CH_W-1:0] second;
		logic [CH_W-1:0] third;
		logic            last;
	} blur_pixel_t;

	logic [PIX_W-1:0] frame_px [0:STORE_DEPTH-1];
	blur_pixel_t      blur_queue [$];
	int               wid, hgt, rad;
	logic             edge_sel;
	logic [1:0]       chans;
	int               pushed, released;

	assign outstanding = blur_queue.size();

	function automatic int clamp_field(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int fold_coord(int c, int len);
		int p;
		if (c >= 0 && c < len) return c;
		if (edge_sel == EDGE_REPLICATE) return (c < 0) ? 0 : len - 1;
		if (c < 0) return (-c) % len;
		p = (2 * len - c - 2) % len;
		if (p < 0) p += len;
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic blur_request(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int total, oy, ox, need, area, sy, sx;
		int sums [3];
		logic [PIX_W-1:0] px;
		blur_pixel_t res;
		total = wid * hgt;
		if (op == OP_PUSH && pushed < total) begin
			px = (chans == CH_COLOUR) ? {c, b, a} : {16'd0, a};
			frame_px[((pushed / wid) * DEF_MAX_WIDTH + pushed % wid) % STORE_DEPTH] = px;
			pushed++;
		end
		if (released >= total) return;
		oy = released / wid;
		ox = released % wid;
		need = (oy + rad > hgt - 1) ? hgt - 1 : oy + rad;
		if (pushed < (need + 1) * wid) return;
		sums = '{0, 0, 0};
		for (int dy = -rad; dy <= rad; dy++) begin
			sy = fold_coord(oy + dy, hgt);
			for (int dx = -rad; dx <= rad; dx++) begin
				sx = fold_coord(ox + dx, wid);
				px = frame_px[(sy * DEF_MAX_WIDTH + sx) % STORE_DEPTH];
				for (int k = 0; k < 3; k++) sums[k] += px[8*k +: 8];
			end
		end
		area = (2 * rad + 1) * (2 * rad + 1);
		res.first  = 8'((sums[0] + area / 2) / area);
		res.second = (chans == CH_COLOUR) ? 8'((sums[1] + area / 2) / area) : 8'd0;
		res.third  = (chans == CH_COLOUR) ? 8'((sums[2] + area / 2) / area) : 8'd0;
		released++;
		res.last = (released >= total);
		if (res.last) begin
			pushed = 0;
			released = 0;
		end
		blur_queue.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_pixel_t want;
		if (!arst_n) begin
			blur_queue.delete();
			mismatches = 0;
			wid = DEF_MAX_WIDTH;
			hgt = DEF_MAX_HEIGHT;
			rad = 1;
			edge_sel = EDGE_REPLICATE;
			chans = 2'd1;
			pushed = 0;
			released = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_FRAME_WIDTH:   wid = clamp_field(pwdata[6:0], DEF_MAX_WIDTH);
					REG_FRAME_HEIGHT:  hgt = clamp_field(pwdata[6:0], DEF_MAX_HEIGHT);
					REG_BLUR_RADIUS:   rad = clamp_field(pwdata[3:0], DEF_MAX_RADIUS);
					REG_EDGE_MODE:     edge_sel = pwdata[0];
					REG_CHANNEL_COUNT: chans = pwdata[1:0];
					default: ;
				endcase
				// any valid register restarts the frame
				if (paddr[4:2] <= REG_CHANNEL_COUNT) begin
					pushed = 0;
					released = 0;
				end
			end
			if (item_valid && !item_stall)
				blur_request(operation, sample_first, sample_second, sample_third);
			if (result_valid && !result_stall) begin
				if (blur_queue.size() == 0) begin
					report_mismatch("unexpected output pixel", blurred_first, 0);
				end else begin
					want = blur_queue.pop_front();
					if (blurred_first !== want.first)
						report_mismatch("blurred_first", blurred_first, want.first);
					if (blurred_second !== want.second)
						report_mismatch("blurred_second", blurred_second, want.second);
					if (blurred_third !== want.third)
						report_mismatch("blurred_third", blurred_third, want.third);
					if (frame_end !== want.last)
						report_mismatch("frame_end", frame_end, want.last);
				end
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Box blur stimulus: walks register settings from the extremes to random
// small frames, streams pixel and flush requests under varying idle and stall
// patterns, and gives the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
	import bbem_pkg::*;

	localparam logic       OP_FLUSH    = ~OP_PUSH;
	localparam logic       EDGE_MIRROR = ~EDGE_REPLICATE;
	localparam logic [2:0] REG_SPARE   = 3'd7;
	localparam int         QUIET_LIMIT = 60000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic              operation = OP_PUSH;
	logic [CH_W-1:0]   sample_first = '0, sample_second = '0, sample_third = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [CH_W-1:0]   blurred_first, blurred_second, blurred_third;
	logic              frame_end;
	int                mismatches, outstanding;

	int idle_pct, stall_pct, item_count, quiet, wd, ht;
	bit pressure_go, pressure_done;

	box_blur_edge_modes uut (.*);
	blur_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stall, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (pressure_go && !pressure_done) begin
				result_stall <= 1'b1;
				repeat (400) @(posedge clk);
				pressure_done = 1'b1;
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
		    (psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			wd = (value[6:0] == 0) ? 1 : (value[6:0] > 64) ? 64 : value[6:0];
		if (idx == REG_FRAME_HEIGHT)
			ht = (value[6:0] == 0) ? 1 : (value[6:0] > 64) ? 64 : value[6:0];
	endtask

	task automatic set_frame(int w, int h, int r, logic edge_sel, int ch);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BLUR_RADIUS, r);
		write_reg(REG_EDGE_MODE, edge_sel);
		write_reg(REG_CHANNEL_COUNT, ch);
	endtask

	task automatic offer(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		sample_first <= a;
		sample_second <= b;
		sample_third <= c;
		do @(posedge clk); while (item_stall);
		item_count++;
	endtask

	// drain, then let a request without output finish
	task automatic settle();
		item_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic run_frame();
		for (int i = 0; i < wd * ht; i++) begin
			if ($urandom_range(99) < 10)
				offer(OP_FLUSH, $urandom, $urandom, $urandom);
			offer(OP_PUSH, $urandom, $urandom, $urandom);
		end
		// mostly flushes; the pushes hit a full frame or start the next one
		for (int i = 0; i < wd * ht + 2; i++)
			offer(($urandom_range(99) < 15) ? OP_PUSH : OP_FLUSH,
			      $urandom, $urandom, $urandom);
	endtask

	initial begin
		int phase;
		idle_pct = 0;
		stall_pct = 0;
		item_count = 0;
		wd = 64;
		ht = 64;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: too few rows for any output
		offer(OP_PUSH, 8'hFF, 8'h00, 8'hFF);
		offer(OP_PUSH, 8'h00, 8'hFF, 8'h00);
		offer(OP_FLUSH, 8'hAA, 8'h55, 8'hAA);
		settle();

		set_frame(2, 2, 1, EDGE_MIRROR, CH_COLOUR);
		offer(OP_PUSH, 8'h00, 8'h00, 8'h00);
		offer(OP_PUSH, 8'hFF, 8'hFF, 8'hFF);
		offer(OP_PUSH, 8'hFF, 8'h00, 8'hFF);
		offer(OP_PUSH, 8'h00, 8'hFF, 8'h00);
		offer(OP_PUSH, 8'hFF, 8'hFF, 8'hFF);
		repeat (4) offer(OP_FLUSH, 8'h00, 8'h00, 8'h00);
		offer(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		settle();

		phase = 0;
		while (item_count < 1200) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			case (phase)
				0: set_frame(64, 1, 1, EDGE_REPLICATE, 1);
				1: set_frame(1, 64, 2, EDGE_MIRROR, CH_COLOUR);
				2: set_frame(0, 0, 0, EDGE_MIRROR, 0);
				3: set_frame(3, 2, 15, EDGE_MIRROR, CH_COLOUR);
				4: set_frame(127, 1, 3, EDGE_MIRROR, 2);
				5: set_frame(2, 3, 15, EDGE_REPLICATE, CH_COLOUR);
				default: set_frame($urandom_range(1, 8), $urandom_range(1, 8),
				                   $urandom_range(1, 4), $urandom_range(1), $urandom_range(3));
			endcase
			if (phase == 7)
				write_reg(REG_SPARE, $urandom);
			if (phase == 6)
				pressure_go = 1'b1;
			run_frame();
			settle();
			phase++;
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bbem_pkg.sv
hdl/bbem_ram.sv
hdl/bbem_regs.sv
hdl/bbem_ctrl.sv
hdl/bbem_dpath.sv
hdl/box_blur_edge_modes.sv
bench/blur_checker.sv
bench/testbench.sv
